// ===== src/sdx_pkg.sv =====
// ----------------------------------------------------------------------------
// sdx_pkg
// Beat types, character constants and the letter-to-digit table shared by
// the phonetic word encoder.
// ----------------------------------------------------------------------------
package sdx_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_word;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       last_of_code;
  } out_beat_t;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;
  localparam logic [2:0] NO_DIGIT      = 3'd0;

  // Digit 1..6 for a mapped lower-case consonant, NO_DIGIT for anything else.
  function automatic logic [2:0] letter_digit(input logic [7:0] c);
    logic [2:0] d;
    d = NO_DIGIT;
    case (c) inside
      "b", "f", "p", "v":                     d = 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
      "d", "t":                               d = 3'd3;
      "l":                                    d = 3'd4;
      "m", "n":                               d = 3'd5;
      "r":                                    d = 3'd6;
      default:                                d = NO_DIGIT;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] upper_ascii(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      u = c - CASE_OFFSET;
    end
    return u;
  endfunction

endpackage

// ===== src/sdx_accum.sv =====
// ----------------------------------------------------------------------------
// sdx_accum
// Word state: lead letter, digit store with run suppression, digit count.
// On the final byte it hands the finished code characters to the emitter.
// ----------------------------------------------------------------------------
module sdx_accum #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        beat_take,
  input  sdx_pkg::in_beat_t           beat,
  output logic                        code_load,
  output logic [CODE_LENGTH-1:0][7:0] code_chars
);
  import sdx_pkg::*;

  localparam int SLOTS = CODE_LENGTH - 1;
  localparam int CW    = $clog2(CODE_LENGTH);

  logic [7:0]          lead_r, lead_nxt;
  logic [SLOTS-1:0][2:0] store_r, store_nxt;
  logic [CW-1:0]       count_r, count_nxt, count_eff;
  logic [2:0]          last_digit_r, last_digit_nxt;
  logic                at_start_r, at_start_nxt;
  logic [2:0]          digit;
  logic                add_digit;

  always_comb begin
    digit          = letter_digit(beat.char_in);
    lead_nxt       = lead_r;
    store_nxt      = store_r;
    count_eff      = count_r;
    last_digit_nxt = last_digit_r;
    at_start_nxt   = at_start_r;
    add_digit      = 1'b0;

    if (at_start_r) begin
      lead_nxt     = upper_ascii(beat.char_in);
      count_eff    = '0;
      at_start_nxt = 1'b0;
    end else if (count_r < CW'(SLOTS) && digit != NO_DIGIT) begin
      // a repeat of the last stored digit is dropped, even across unmapped bytes
      add_digit = (count_r == '0) || (last_digit_r != digit);
    end

    if (add_digit) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (count_r == CW'(i)) begin
          store_nxt[i] = digit;
        end
      end
      count_eff      = count_r + CW'(1);
      last_digit_nxt = digit;
    end

    count_nxt = count_eff;
    if (beat.end_of_word) begin
      count_nxt    = '0;
      at_start_nxt = 1'b1;
    end
  end

  always_comb begin
    code_load     = beat_take && beat.end_of_word;
    code_chars[0] = lead_nxt;
    for (int k = 1; k < CODE_LENGTH; k++) begin
      code_chars[k] = (CW'(k - 1) < count_eff) ? (ASCII_ZERO | {5'b0, store_nxt[k-1]})
                                                : ASCII_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r     <= '0;
      count_r    <= '0;
      at_start_r <= 1'b1;
    end else if (beat_take) begin
      lead_r     <= lead_nxt;
      count_r    <= count_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take) begin
      store_r      <= store_nxt;
      last_digit_r <= last_digit_nxt;
    end
  end

endmodule

// ===== src/sdx_emit.sv =====
// ----------------------------------------------------------------------------
// sdx_emit
// Output shift register: loads a finished code and plays it out one
// character per beat, flagging the last one.
// ----------------------------------------------------------------------------
module sdx_emit #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        code_load,
  input  logic [CODE_LENGTH-1:0][7:0] code_chars,
  output logic                        load_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sdx_pkg::out_beat_t          out_data
);
  import sdx_pkg::*;

  localparam int LW = $clog2(CODE_LENGTH + 1);

  logic [CODE_LENGTH-1:0][7:0] shreg_r, shreg_nxt;
  logic [LW-1:0]               left_r, left_nxt;
  logic                        out_take;
  logic                        on_last;

  assign on_last    = (left_r == LW'(1));
  assign out_valid  = (left_r != '0);
  assign out_take   = out_valid && !out_stall;
  // a new code may load in the same cycle the last character of the old one goes
  assign load_ready = !out_valid || (out_take && on_last);

  assign out_data.code_char    = shreg_r[0];
  assign out_data.last_of_code = on_last;

  always_comb begin
    shreg_nxt = shreg_r;
    left_nxt  = left_r;
    if (code_load) begin
      shreg_nxt = code_chars;
      left_nxt  = LW'(CODE_LENGTH);
    end else if (out_take) begin
      for (int i = 0; i < CODE_LENGTH - 1; i++) begin
        shreg_nxt[i] = shreg_r[i+1];
      end
      shreg_nxt[CODE_LENGTH-1] = ASCII_ZERO;
      left_nxt = left_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
  end

endmodule

// ===== src/soundex_word_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// soundex_word_encoder_unit
// Streaming phonetic (Soundex-style) word encoder, one byte per beat in,
// one code character per beat out.
// ----------------------------------------------------------------------------
// Takes one byte every cycle unless it stalls a final byte, as below. The final
// byte of a word hands a finished code of CODE_LENGTH characters to an output
// shift register, which sends one character per beat while out_stall is low.
// A final byte is held off (in_stall high) while the previous code still has
// characters to send, unless its last character leaves in that same cycle;
// other bytes are never stalled. With the output free, words of CODE_LENGTH
// bytes or more therefore stream at one byte per cycle.
// ----------------------------------------------------------------------------
module soundex_word_encoder_unit #(
  parameter int CODE_LENGTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sdx_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sdx_pkg::out_beat_t out_data
);
  import sdx_pkg::*;

  logic                        load_ready;
  logic                        beat_take;
  logic                        code_load;
  logic [CODE_LENGTH-1:0][7:0] code_chars;

  assign in_stall  = in_data.end_of_word && !load_ready;
  assign beat_take = in_valid && !in_stall;

  sdx_accum #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_take  (beat_take),
    .beat       (in_data),
    .code_load  (code_load),
    .code_chars (code_chars)
  );

  sdx_emit #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .code_load  (code_load),
    .code_chars (code_chars),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the phonetic word encoder: words go in one byte per beat, and each
// code coming out is compared character by character with a predicted code.
// ----------------------------------------------------------------------------
module testbench;
  import sdx_pkg::*;

  localparam int CODE_LEN   = 4;
  localparam int SLOTS      = CODE_LEN - 1;
  localparam int IDLE_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  soundex_word_encoder_unit #(.CODE_LENGTH(CODE_LEN)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [7:0] word_lead = '0;
  logic [2:0] held_digits [SLOTS];
  int         held_count = 0;
  bit         starting_word = 1'b1;
  out_beat_t  code_queue [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic logic [2:0] digit_of(input logic [7:0] c);
    case (c)
      "b", "f", "p", "v":                     return 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": return 3'd2;
      "d", "t":                               return 3'd3;
      "l":                                    return 3'd4;
      "m", "n":                               return 3'd5;
      "r":                                    return 3'd6;
      default:                                return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) return c - CASE_OFFSET;
    return c;
  endfunction

  // Advance the predicted encoder by one accepted byte; queue the code on a word end.
  function automatic void encode_byte(input in_beat_t beat);
    logic [2:0] d;
    out_beat_t  r;
    if (starting_word) begin
      word_lead = upcase(beat.char_in);
      held_count = 0;
      starting_word = 1'b0;
    end else if (held_count < SLOTS) begin
      d = digit_of(beat.char_in);
      // the lead letter never takes part in duplicate removal
      if (d != 3'd0 && (held_count == 0 || held_digits[held_count-1] != d)) begin
        held_digits[held_count] = d;
        held_count++;
      end
    end
    if (beat.end_of_word) begin
      for (int k = 0; k < CODE_LEN; k++) begin
        if (k == 0) r.code_char = word_lead;
        else if (k - 1 < held_count) r.code_char = ASCII_ZERO + held_digits[k-1];
        else r.code_char = ASCII_ZERO;
        r.last_of_code = (k == CODE_LEN - 1);
        code_queue.push_back(r);
      end
      held_count = 0;
      starting_word = 1'b1;
    end
  endfunction

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result check against the oldest queued character.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (code_queue.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %h last %b",
                 $time, out_data.code_char, out_data.last_of_code);
        fail_count++;
      end else begin
        want = code_queue.pop_front();
        if (out_data.code_char !== want.code_char) begin
          $display("%0t: code_char mismatch, expected %h actual %h",
                   $time, want.code_char, out_data.code_char);
          fail_count++;
        end
        if (out_data.last_of_code !== want.last_of_code) begin
          $display("%0t: last_of_code mismatch, expected %b actual %b",
                   $time, want.last_of_code, out_data.last_of_code);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("soundex_word_encoder_unit regression: fail");
        $finish;
      end
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_byte(input logic [7:0] c, input logic eow);
    in_beat_t beat;
    beat.char_in = c;
    beat.end_of_word = eow;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_byte(beat);
  endtask

  task automatic send_word(input string s, input bit finish);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], finish && (i == s.len() - 1));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (code_queue.size() != 0) @(posedge clk);
  endtask

  task automatic random_words(input int n_bytes);
    int sent;
    int len;
    logic [7:0] c;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 8);
      for (int i = 0; i < len; i++) begin
        // mostly lower-case letters, some arbitrary bytes as noise
        if ($urandom_range(3) != 0) c = 8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z));
        else c = 8'($urandom_range(255));
        send_byte(c, i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_single_byte_words();
    send_byte("a", 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_digit_rules();
    send_word("pfbzk", 1'b1);   // lead does not seed, adjacent duplicates drop
    send_word("dc", 1'b0);      // unmapped bytes keep a run alive
    send_byte(8'h80, 1'b0);
    send_word("Hcm", 1'b1);
    send_word("ltrmnv", 1'b1);  // store full: trailing letters ignored
    wait_for_drain();
  endtask

  task automatic test_random_words(input int n_bytes, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    random_words(n_bytes);
    wait_for_drain();
  endtask

  // Receiver holds off while short words keep coming, so the encoder backs up.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 60;
    for (int i = 0; i < 16; i++) send_byte(8'($urandom_range(255)), (i % 2) == 1);
    wait_for_drain();
  endtask

  initial begin
    send_idle_pct = 21;
    recv_idle_pct = 66;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_byte_words();
    test_digit_rules();
    test_random_words(30, 21, 66);
    test_random_words(30, 66, 21);
    test_random_words(25, 0, 0);
    test_output_backpressure();
    repeat (2 * CODE_LEN + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("soundex_word_encoder_unit regression: pass");
    end else begin
      $display("soundex_word_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule
